FILE: rtl/core/jpd_pkg.sv
// Package for the jack plug detect and trigger filter block.
// Sizes, action codes, the tick control struct and the popcount helper.
// No dependencies.
`default_nettype none

package jpd_pkg;

	localparam int HISTORY_LEN     = 10;
	localparam int JACKS           = 4;
	localparam int THR_W           = 4;
	localparam int SLOT_W          = $clog2(HISTORY_LEN);
	localparam int CNT_W           = $clog2(HISTORY_LEN + 1);
	localparam int CMP_W           = (CNT_W > THR_W) ? CNT_W : THR_W;
	localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(8);

	// jack order in level and flag vectors
	localparam int J_GATE1 = 0;
	localparam int J_TRIG1 = 1;
	localparam int J_GATE2 = 2;
	localparam int J_TRIG2 = 3;

	typedef enum logic {
		ACT_TICK = 1'b0,
		ACT_POLL = 1'b1
	} action_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic              probe;
	} tick_t;

	function automatic logic [CNT_W-1:0] count_ones(input logic [HISTORY_LEN-1:0] v);
		logic [CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < HISTORY_LEN; i++) begin
			n = n + CNT_W'(v[i]);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/jack_plug_detect_trigger_filter.sv
// Jack plug detection by normalisation probe with trigger filtering.
// One result beat per input beat, through an input register, then a result
// register; a new beat is taken every cycle while results drain. A probe tick
// (action 0) toggles the probe, records per-jack matches in the history ring and
// refreshes the unplugged flags; a poll (action 1) gives rising-edge trigger
// pulses for channels whose gate and trigger jacks are both plugged.
// Threshold (reset value 8) is written through cfg_we/cfg_wdata, by the user only while idle;
// the block does not enforce that. Depends on jpd_pkg, jpd_hist, jpd_trig_filter.
`default_nettype none

module jack_plug_detect_trigger_filter (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [jpd_pkg::THR_W-1:0] cfg_wdata,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic                     action,
	input  wire logic                     gate1_level,
	input  wire logic                     trig1_level,
	input  wire logic                     gate2_level,
	input  wire logic                     trig2_level,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic                          probe_out,
	output logic                          gate1_unplugged,
	output logic                          trig1_unplugged,
	output logic                          gate2_unplugged,
	output logic                          trig2_unplugged,
	output logic                          trig1_pulse,
	output logic                          trig2_pulse
);
	import jpd_pkg::*;

	logic [THR_W-1:0]  thr_q;
	logic              probe_q;
	logic [SLOT_W-1:0] slot_q;
	logic [JACKS-1:0]  flags_q;

	logic              v_s1;
	action_t           act_s1;
	logic [JACKS-1:0]  lvl_s1;

	logic              adv;
	logic              is_tick;
	tick_t             tick;
	logic [JACKS-1:0]  hit;
	logic [1:0]        pulse;
	logic [JACKS-1:0]  flags_nxt;
	logic [SLOT_W-1:0] slot_nxt;

	assign adv      = v_s1 && (!out_valid || out_ready);
	assign in_ready = !v_s1 || adv;
	assign is_tick  = (act_s1 == ACT_TICK);

	assign tick.en    = adv && is_tick;
	assign tick.slot  = slot_q;
	assign tick.probe = !probe_q;

	assign flags_nxt = is_tick ? hit : flags_q;
	assign slot_nxt  = (slot_q == SLOT_W'(HISTORY_LEN - 1)) ? '0 : slot_q + 1'b1;

	for (genvar j = 0; j < JACKS; j++) begin : g_jack
		jpd_hist u_hist (
			.clk       (clk),
			.arst_n    (arst_n),
			.tick      (tick),
			.level     (lvl_s1[j]),
			.threshold (thr_q),
			.unplugged (hit[j])
		);
	end

	jpd_trig_filter u_trig (
		.clk        (clk),
		.arst_n     (arst_n),
		.poll_en    (adv && !is_tick),
		.trig_level ({lvl_s1[J_TRIG2], lvl_s1[J_TRIG1]}),
		.flags      (flags_q),
		.pulse      (pulse)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THRESHOLD_RESET;
			probe_q <= 1'b0;
			slot_q  <= '0;
			flags_q <= '1;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (tick.en) begin
				probe_q <= !probe_q;
				slot_q  <= slot_nxt;
				flags_q <= hit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_s1 <= action_t'(action);
			lvl_s1 <= {trig2_level, gate2_level, trig1_level, gate1_level};
		end
		if (adv) begin
			probe_out       <= is_tick ? !probe_q : probe_q;
			gate1_unplugged <= flags_nxt[J_GATE1];
			trig1_unplugged <= flags_nxt[J_TRIG1];
			gate2_unplugged <= flags_nxt[J_GATE2];
			trig2_unplugged <= flags_nxt[J_TRIG2];
			trig1_pulse     <= !is_tick && pulse[0];
			trig2_pulse     <= !is_tick && pulse[1];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/jpd_hist.sv
// Match history ring and unplugged decision for one jack.
// Depends on jpd_pkg.
`default_nettype none

module jpd_hist (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire jpd_pkg::tick_t           tick,
	input  wire logic                     level,
	input  wire logic [jpd_pkg::THR_W-1:0] threshold,
	output logic                          unplugged
);
	import jpd_pkg::*;

	logic [HISTORY_LEN-1:0] ring_q;
	logic [HISTORY_LEN-1:0] ring_nxt;

	always_comb begin
		ring_nxt = ring_q;
		ring_nxt[tick.slot] = (level == tick.probe);
	end

	assign unplugged = CMP_W'(count_ones(ring_nxt)) >= CMP_W'(threshold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q <= '0;
		end else if (tick.en) begin
			ring_q <= ring_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/jpd_trig_filter.sv
// Rising-edge trigger filter for both channels, gated by plug state.
// Depends on jpd_pkg.
`default_nettype none

module jpd_trig_filter (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     poll_en,
	input  wire logic [1:0]               trig_level,
	input  wire logic [jpd_pkg::JACKS-1:0] flags,
	output logic      [1:0]               pulse
);
	import jpd_pkg::*;

	logic [1:0] last_q;

	assign pulse[0] = !flags[J_GATE1] && !flags[J_TRIG1] && trig_level[0] && !last_q[0];
	assign pulse[1] = !flags[J_GATE2] && !flags[J_TRIG2] && trig_level[1] && !last_q[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (poll_en) begin
			last_q <= trig_level;
		end
	end

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Testbench for jack_plug_detect_trigger_filter: directed stimulus table, then random
// ticks and polls under several threshold settings, checked beat by beat.
// Depends on jpd_pkg and the jack_plug_detect_trigger_filter RTL.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import jpd_pkg::*;

	localparam int CYCLE_LIMIT  = 100000;
	localparam int PHASE_ITEMS  = 100;
	localparam int PLAN_ROWS    = 20;

	typedef struct packed {
		logic probe;
		logic gate1_u;
		logic trig1_u;
		logic gate2_u;
		logic trig2_u;
		logic trig1_p;
		logic trig2_p;
	} jack_result_t;

	typedef struct {
		action_t      act;
		logic [3:0]   lv;
		bit           typed;
		jack_result_t res;
	} plan_row_t;

	localparam jack_result_t NOT_TYPED = '0;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [THR_W-1:0] cfg_wdata = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             action = 1'b0;
	logic             gate1_level = 1'b0;
	logic             trig1_level = 1'b0;
	logic             gate2_level = 1'b0;
	logic             trig2_level = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic             probe_out;
	logic             gate1_unplugged;
	logic             trig1_unplugged;
	logic             gate2_unplugged;
	logic             trig2_unplugged;
	logic             trig1_pulse;
	logic             trig2_pulse;

	jack_plug_detect_trigger_filter dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.gate1_level     (gate1_level),
		.trig1_level     (trig1_level),
		.gate2_level     (gate2_level),
		.trig2_level     (trig2_level),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.probe_out       (probe_out),
		.gate1_unplugged (gate1_unplugged),
		.trig1_unplugged (trig1_unplugged),
		.gate2_unplugged (gate2_unplugged),
		.trig2_unplugged (trig2_unplugged),
		.trig1_pulse     (trig1_pulse),
		.trig2_pulse     (trig2_pulse)
	);

	// jack state mirror
	logic                   probe_st;
	logic [HISTORY_LEN-1:0] hist_st [JACKS];
	int                     slot_st;
	logic [JACKS-1:0]       flags_st;
	logic [1:0]             last_trig_st;
	logic [THR_W-1:0]       thr_st;

	jack_result_t jack_results_due [$];
	jack_result_t due;
	int           errors = 0;
	int           cycles = 0;
	bit           calm = 1'b0;

	// levels are {trig2, gate2, trig1, gate1}
	plan_row_t plan [PLAN_ROWS] = '{
		'{ACT_POLL, 4'hF, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
		'{ACT_TICK, 4'h0, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{ACT_POLL, 4'hF, 1'b0, NOT_TYPED},
		'{ACT_POLL, 4'h0, 1'b0, NOT_TYPED},
		'{ACT_POLL, 4'hF, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}},
		'{ACT_TICK, 4'h0, 1'b0, NOT_TYPED},
		'{ACT_TICK, 4'hF, 1'b0, NOT_TYPED},
		'{ACT_TICK, 4'h0, 1'b0, NOT_TYPED},
		'{ACT_TICK, 4'hF, 1'b0, NOT_TYPED},
		'{ACT_TICK, 4'h0, 1'b0, NOT_TYPED},
		'{ACT_TICK, 4'hF, 1'b0, NOT_TYPED},
		'{ACT_TICK, 4'h0, 1'b0, NOT_TYPED},
		'{ACT_TICK, 4'hF, 1'b0, NOT_TYPED},
		'{ACT_POLL, 4'hF, 1'b0, NOT_TYPED},
		'{ACT_TICK, 4'hA, 1'b0, NOT_TYPED},
		'{ACT_TICK, 4'h5, 1'b0, NOT_TYPED},
		'{ACT_TICK, 4'hF, 1'b0, NOT_TYPED},
		'{ACT_TICK, 4'h0, 1'b0, NOT_TYPED},
		'{ACT_POLL, 4'h0, 1'b0, NOT_TYPED},
		'{ACT_POLL, 4'hA, 1'b0, NOT_TYPED}
	};

	always #1ns clk = ~clk;

	task automatic advance_jacks(input action_t act, input logic [3:0] lv,
			output jack_result_t r);
		int n;
		r = '0;
		if (act == ACT_TICK) begin
			probe_st = ~probe_st;
			for (int j = 0; j < JACKS; j++) begin
				hist_st[j][slot_st] = (lv[j] == probe_st);
				n = $countones(hist_st[j]);
				flags_st[j] = (n >= int'(thr_st));
			end
			slot_st = (slot_st + 1 >= HISTORY_LEN) ? 0 : slot_st + 1;
		end else begin
			if (!flags_st[J_GATE1] && !flags_st[J_TRIG1])
				r.trig1_p = lv[J_TRIG1] & ~last_trig_st[0];
			if (!flags_st[J_GATE2] && !flags_st[J_TRIG2])
				r.trig2_p = lv[J_TRIG2] & ~last_trig_st[1];
			last_trig_st = {lv[J_TRIG2], lv[J_TRIG1]};
		end
		r.probe   = probe_st;
		r.gate1_u = flags_st[J_GATE1];
		r.trig1_u = flags_st[J_TRIG1];
		r.gate2_u = flags_st[J_GATE2];
		r.trig2_u = flags_st[J_TRIG2];
	endtask

	task automatic send_beat(input action_t act, input logic [3:0] lv, input bit typed,
			input jack_result_t typed_res);
		jack_result_t r;
		@(negedge clk);
		while (!calm && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		gate1_level <= lv[J_GATE1];
		trig1_level <= lv[J_TRIG1];
		gate2_level <= lv[J_GATE2];
		trig2_level <= lv[J_TRIG2];
		do @(posedge clk); while (!in_ready);
		advance_jacks(act, lv, r);
		jack_results_due.push_back(typed ? typed_res : r);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (jack_results_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] v);
		drain_results();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		thr_st = v;
	endtask

	function automatic void check_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			$error("%s: expected %0b, got %0b", name, want, got);
			errors++;
		end
	endfunction

	always @(negedge clk) out_ready <= calm || ($urandom_range(99) >= 9);

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			if (jack_results_due.size() == 0) begin
				$error("result beat with nothing outstanding");
				errors++;
			end else begin
				due = jack_results_due.pop_front();
				check_field("probe_out", due.probe, probe_out);
				check_field("gate1_unplugged", due.gate1_u, gate1_unplugged);
				check_field("trig1_unplugged", due.trig1_u, trig1_unplugged);
				check_field("gate2_unplugged", due.gate2_u, gate2_unplugged);
				check_field("trig2_unplugged", due.trig2_u, trig2_unplugged);
				check_field("trig1_pulse", due.trig1_p, trig1_pulse);
				check_field("trig2_pulse", due.trig2_p, trig2_pulse);
			end
		end
	end

	initial begin
		logic [THR_W-1:0] thr_plan [6];
		logic [3:0]       plugged;
		logic [3:0]       held;
		logic [3:0]       lv;
		action_t          act;

		probe_st     = 1'b0;
		slot_st      = 0;
		flags_st     = '1;
		last_trig_st = '0;
		thr_st       = THRESHOLD_RESET;
		for (int j = 0; j < JACKS; j++) hist_st[j] = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) send_beat(plan[i].act, plan[i].lv, plan[i].typed, plan[i].res);

		thr_plan = '{THR_W'(0), THR_W'(15), THR_W'(HISTORY_LEN), THR_W'(HISTORY_LEN + 1),
			THR_W'($urandom_range(1, 9)), THR_W'($urandom_range(1, 9))};
		foreach (thr_plan[p]) begin
			write_threshold(thr_plan[p]);
			calm    = (p == 2);
			plugged = 4'($urandom);
			held    = 4'($urandom);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				act = ($urandom_range(99) < 45) ? ACT_POLL : ACT_TICK;
				if ($urandom_range(99) < 10) begin
					lv = 4'($urandom);
				end else begin
					for (int j = 0; j < JACKS; j++) begin
						if ($urandom_range(99) < ((j == J_TRIG1 || j == J_TRIG2) ? 25 : 8))
							held[j] = ~held[j];
						if (act == ACT_TICK && $urandom_range(99) < 3)
							plugged[j] = ~plugged[j];
						// an empty jack follows the probe through its normal contact
						if (plugged[j])
							lv[j] = held[j];
						else
							lv[j] = (act == ACT_TICK) ? ~probe_st : probe_st;
					end
				end
				send_beat(act, lv, 1'b0, NOT_TYPED);
			end
		end
		calm = 1'b0;

		drain_results();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
rtl/core/jpd_pkg.sv
rtl/core/jpd_hist.sv
rtl/core/jpd_trig_filter.sv
rtl/core/jack_plug_detect_trigger_filter.sv
verif/testbench.sv
